[hw/rtl/ils_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Types and constants shared by the intercept lead solver pipeline.
// ----------------------------------------------------------------------------
package ils_pkg;

	typedef struct packed {
		logic signed [31:0] shooter_px;
		logic signed [31:0] shooter_py;
		logic signed [31:0] shooter_pz;
		logic signed [31:0] shooter_vx;
		logic signed [31:0] shooter_vy;
		logic signed [31:0] shooter_vz;
		logic signed [31:0] target_px;
		logic signed [31:0] target_py;
		logic signed [31:0] target_pz;
		logic signed [31:0] target_vx;
		logic signed [31:0] target_vy;
		logic signed [31:0] target_vz;
	} query_t;

	typedef struct packed {
		logic signed [31:0] lead_x;
		logic signed [31:0] lead_y;
		logic signed [31:0] lead_z;
		logic [31:0]        lead_time;
		logic [1:0]         solve_status;
	} result_t;

	localparam logic [1:0] ST_SOLVED    = 2'd0;
	localparam logic [1:0] ST_NO_MOTION = 2'd1;
	localparam logic [1:0] ST_NO_ROOT   = 2'd2;
	localparam logic [1:0] ST_ZERO_DIV  = 2'd3;

	localparam logic [61:0] NEAR_ZERO_SQ = 62'd16778;

	localparam int SQ_STAGES  = 63;
	localparam int DIV_STAGES = 32;

	typedef struct packed {
		logic [2:0][31:0] tp;
		logic [2:0][30:0] v;
		logic [1:0]       status;
		logic             rel;
		logic             lin;
		logic             a_pos;
		logic             disc_ok;
		logic [62:0]      h;
		logic [61:0]      c;
		logic [61:0]      hmag;
		logic [61:0]      amag;
		logic             use_div;
		logic             sat;
	} side_t;

	function automatic logic [30:0] clamp31(input logic signed [32:0] x);
		logic [30:0] r;
		if (x > 33'sd1073741823)
			r = 31'h3FFF_FFFF;
		else if (x < -33'sd1073741824)
			r = 31'h4000_0000;
		else
			r = x[30:0];
		return r;
	endfunction

endpackage

[hw/rtl/ils_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_sqrt
// Floor square root of a 126-bit radicand, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module ils_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [125:0]        in_rad,
	input  ils_pkg::side_t      in_side,
	output logic                out_vld,
	output logic [62:0]         out_root,
	output ils_pkg::side_t      out_side
);
	import ils_pkg::*;

	logic [65:0]  rem_s  [SQ_STAGES];
	logic [62:0]  root_s [SQ_STAGES];
	logic [125:0] rad_s  [SQ_STAGES];
	side_t        side_s [SQ_STAGES];
	logic         vld_s  [SQ_STAGES];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		logic [65:0]  rem_i;
		logic [62:0]  root_i;
		logic [125:0] rad_i;
		side_t        side_i;
		logic         vld_i;
		logic [65:0]  rem_sh;
		logic [65:0]  trial;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = in_rad;
			assign side_i = in_side;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign rem_sh = {rem_i[63:0], rad_i[125:124]};
		assign trial  = {1'b0, root_i, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {root_i[61:0], ge};
				rad_s[k]  <= {rad_i[123:0], 2'b00};
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[SQ_STAGES-1];
	assign out_root = root_s[SQ_STAGES-1];
	assign out_side = side_s[SQ_STAGES-1];

endmodule

[hw/rtl/ils_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_div
// Restoring divider, 80-bit numerator by 63-bit divisor, one quotient bit
// per pipeline stage. The numerator's upper part must be below the divisor.
// ----------------------------------------------------------------------------
module ils_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [79:0]         in_num,
	input  logic [62:0]         in_den,
	input  ils_pkg::side_t      in_side,
	output logic                out_vld,
	output logic [31:0]         out_quo,
	output ils_pkg::side_t      out_side
);
	import ils_pkg::*;

	logic [62:0] rem_s  [DIV_STAGES];
	logic [31:0] quo_s  [DIV_STAGES];
	logic [31:0] nb_s   [DIV_STAGES];
	logic [62:0] den_s  [DIV_STAGES];
	side_t       side_s [DIV_STAGES];
	logic        vld_s  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [62:0] rem_i;
		logic [31:0] quo_i;
		logic [31:0] nb_i;
		logic [62:0] den_i;
		side_t       side_i;
		logic        vld_i;
		logic [63:0] r2;
		logic [63:0] diff;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_i  = {15'b0, in_num[79:32]};
			assign quo_i  = '0;
			assign nb_i   = in_num[31:0];
			assign den_i  = in_den;
			assign side_i = in_side;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign nb_i   = nb_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign r2   = {rem_i, nb_i[31]};
		assign diff = r2 - {1'b0, den_i};
		assign ge   = r2 >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[62:0] : r2[62:0];
				quo_s[k]  <= {quo_i[30:0], ge};
				nb_s[k]   <= {nb_i[30:0], 1'b0};
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[DIV_STAGES-1];
	assign out_quo  = quo_s[DIV_STAGES-1];
	assign out_side = side_s[DIV_STAGES-1];

endmodule

[hw/rtl/intercept_lead_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intercept_lead_solver
// Solves |P + V t| = S t for the intercept time and aim point.
//
//   channel  signals                        item
//   in       in_valid  in_ready  in_data    query_t, one target query
//   out      out_valid out_ready out_data   result_t, aim point and time
//   cfg      cfg_valid cfg_ready cfg_data   projectile speed, unsigned Q19.12
//
// One item enters per cycle while the pipeline advances; it has 6 setup stages, 63
// square root stages, 2 quotient setup stages, 32 divider stages and 2 aim
// point stages. The whole pipeline holds while a result waits on out_ready.
// Reset clears valid bits and sets the projectile speed to 0.
// ----------------------------------------------------------------------------
module intercept_lead_solver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ils_pkg::query_t     in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ils_pkg::result_t    out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [30:0]         cfg_data
);
	import ils_pkg::*;

	logic        adv;
	logic [30:0] speed_q;

	logic signed [31:0] sp [3], sv [3], tpi [3], tvi [3];

	logic [30:0] p_s1 [3], v_s1 [3];
	logic [31:0] tp_s1 [3];
	logic [61:0] s2_s1;
	logic        vld_s1;

	logic signed [61:0] vv_s2 [3], pp_s2 [3], vp_s2 [3];
	logic [30:0] v_s2 [3];
	logic [31:0] tp_s2 [3];
	logic [61:0] s2_s2;
	logic        vld_s2;

	side_t side_s3;
	logic  vld_s3;
	logic [61:0] v2_c, c_c;
	logic signed [62:0] h_c, a_c;
	logic [62:0] amag_c, hmag_c;

	logic [61:0] hh_hh_s4, hh_hl_s4, hh_ll_s4;
	logic [61:0] ac_hh_s4, ac_hl_s4, ac_lh_s4, ac_ll_s4;
	side_t side_s4;
	logic  vld_s4;

	logic [123:0] hh_s5, ac_s5;
	side_t side_s5;
	logic  vld_s5;

	logic [125:0] d_s6;
	side_t side_s6;
	side_t side6_c;
	logic  vld_s6;

	logic        sq_vld;
	logic [62:0] sq_root;
	side_t       sq_side;

	logic signed [64:0] base_c, n1_c, n2_c, nsel_c;
	logic [79:0] num_s7;
	logic [62:0] den_s7;
	side_t side_s7;
	side_t side7_c;
	logic  vld_s7;

	logic [79:0] num_s8;
	logic [62:0] den_s8;
	side_t side_s8;
	side_t side8_c;
	logic  vld_s8;

	logic        dv_vld;
	logic [31:0] dv_quo;
	side_t       dv_side;
	logic [31:0] t_c;

	logic signed [63:0] prod_s9 [3];
	logic [31:0] tp_s9 [3];
	logic [31:0] t_s9;
	logic [1:0]  status_s9;
	logic        vld_s9;

	logic signed [63:0] lead_c [3];
	logic [31:0] lead_sat_c [3];
	result_t out_q;
	logic    out_vld_q;

	assign adv       = !out_vld_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			speed_q <= '0;
		else if (cfg_valid)
			speed_q <= cfg_data;
	end

	assign sp[0]  = in_data.shooter_px;
	assign sp[1]  = in_data.shooter_py;
	assign sp[2]  = in_data.shooter_pz;
	assign sv[0]  = in_data.shooter_vx;
	assign sv[1]  = in_data.shooter_vy;
	assign sv[2]  = in_data.shooter_vz;
	assign tpi[0] = in_data.target_px;
	assign tpi[1] = in_data.target_py;
	assign tpi[2] = in_data.target_pz;
	assign tvi[0] = in_data.target_vx;
	assign tvi[1] = in_data.target_vy;
	assign tvi[2] = in_data.target_vz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= sq_vld;
			vld_s8    <= vld_s7;
			vld_s9    <= dv_vld;
			out_vld_q <= vld_s9;
		end
	end

	always_comb begin
		v2_c = '0;
		c_c  = '0;
		h_c  = '0;
		for (int i = 0; i < 3; i++) begin
			v2_c = v2_c + vv_s2[i][61:0];
			c_c  = c_c + pp_s2[i][61:0];
			h_c  = h_c + 63'(vp_s2[i]);
		end
		a_c    = $signed({1'b0, v2_c}) - $signed({1'b0, s2_s2});
		amag_c = a_c[62] ? 63'(-a_c) : a_c;
		hmag_c = h_c[62] ? 63'(-h_c) : h_c;
	end

	always_comb begin
		side6_c         = side_s5;
		side6_c.disc_ok = !side_s5.a_pos || (hh_s5 >= ac_s5);
		if (side_s5.rel)
			side6_c.status = ST_NO_MOTION;
		else if (side_s5.lin && side_s5.h == '0)
			side6_c.status = ST_ZERO_DIV;
		else if (!side_s5.lin && side_s5.a_pos && hh_s5 < ac_s5)
			side6_c.status = ST_NO_ROOT;
		else
			side6_c.status = ST_SOLVED;
	end

	always_comb begin
		base_c = sq_side.a_pos ? -65'(signed'(sq_side.h)) : 65'(signed'(sq_side.h));
		n1_c   = base_c - $signed({2'b00, sq_root});
		n2_c   = base_c + $signed({2'b00, sq_root});
		if (n1_c > 0)
			nsel_c = n1_c;
		else if (n2_c > 0)
			nsel_c = n2_c;
		else
			nsel_c = '0;
	end

	always_comb begin
		side7_c = sq_side;
		if (sq_side.lin)
			side7_c.use_div = !sq_side.rel && sq_side.h[62];
		else
			side7_c.use_div = !sq_side.rel && sq_side.disc_ok && (nsel_c > 0);
	end

	always_comb begin
		side8_c     = side_s7;
		side8_c.sat = (den_s7 == '0) || ({15'b0, num_s7} >= {den_s7, 32'b0});
	end

	assign t_c = !dv_side.use_div ? 32'd0 : (dv_side.sat ? 32'hFFFF_FFFF : dv_quo);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lead_c[i] = $signed({{32{tp_s9[i][31]}}, tp_s9[i]}) + (prod_s9[i] >>> 16);
			if (lead_c[i] > 64'sd2147483647)
				lead_sat_c[i] = 32'h7FFF_FFFF;
			else if (lead_c[i] < -64'sd2147483648)
				lead_sat_c[i] = 32'h8000_0000;
			else
				lead_sat_c[i] = lead_c[i][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i]  <= clamp31({tpi[i][31], tpi[i]} - {sp[i][31], sp[i]});
				v_s1[i]  <= clamp31({tvi[i][31], tvi[i]} - {sv[i][31], sv[i]});
				tp_s1[i] <= tpi[i];
				vv_s2[i] <= $signed(v_s1[i]) * $signed(v_s1[i]);
				pp_s2[i] <= $signed(p_s1[i]) * $signed(p_s1[i]);
				vp_s2[i] <= $signed(v_s1[i]) * $signed(p_s1[i]);
				v_s2[i]  <= v_s1[i];
				tp_s2[i] <= tp_s1[i];
			end
			s2_s1 <= 62'(speed_q) * 62'(speed_q);
			s2_s2 <= s2_s1;

			for (int i = 0; i < 3; i++) begin
				side_s3.tp[i] <= tp_s2[i];
				side_s3.v[i]  <= v_s2[i];
			end
			side_s3.status  <= ST_SOLVED;
			side_s3.rel     <= v2_c < NEAR_ZERO_SQ;
			side_s3.lin     <= amag_c[61:0] < NEAR_ZERO_SQ;
			side_s3.a_pos   <= !a_c[62] && (a_c != 0);
			side_s3.disc_ok <= 1'b1;
			side_s3.h       <= h_c;
			side_s3.c       <= c_c;
			side_s3.hmag    <= hmag_c[61:0];
			side_s3.amag    <= amag_c[61:0];
			side_s3.use_div <= 1'b0;
			side_s3.sat     <= 1'b0;

			hh_hh_s4 <= 62'(side_s3.hmag[61:31]) * 62'(side_s3.hmag[61:31]);
			hh_hl_s4 <= 62'(side_s3.hmag[61:31]) * 62'(side_s3.hmag[30:0]);
			hh_ll_s4 <= 62'(side_s3.hmag[30:0]) * 62'(side_s3.hmag[30:0]);
			ac_hh_s4 <= 62'(side_s3.amag[61:31]) * 62'(side_s3.c[61:31]);
			ac_hl_s4 <= 62'(side_s3.amag[61:31]) * 62'(side_s3.c[30:0]);
			ac_lh_s4 <= 62'(side_s3.amag[30:0]) * 62'(side_s3.c[61:31]);
			ac_ll_s4 <= 62'(side_s3.amag[30:0]) * 62'(side_s3.c[30:0]);
			side_s4  <= side_s3;

			hh_s5 <= {hh_hh_s4, 62'b0} + {30'b0, hh_hl_s4, 32'b0} + {62'b0, hh_ll_s4};
			ac_s5 <= {ac_hh_s4, 62'b0} + {31'b0, ac_hl_s4, 31'b0}
				+ {31'b0, ac_lh_s4, 31'b0} + {62'b0, ac_ll_s4};
			side_s5 <= side_s4;

			d_s6 <= side_s5.a_pos ? {2'b00, hh_s5} - {2'b00, ac_s5}
				: {2'b00, hh_s5} + {2'b00, ac_s5};
			side_s6 <= side6_c;

			side_s7 <= side7_c;
			if (sq_side.lin) begin
				num_s7 <= {3'b0, sq_side.c, 15'b0};
				den_s7 <= {1'b0, sq_side.hmag};
			end else begin
				num_s7 <= {1'b0, nsel_c[62:0], 16'b0};
				den_s7 <= {1'b0, sq_side.amag};
			end

			num_s8  <= num_s7;
			den_s8  <= den_s7;
			side_s8 <= side8_c;

			for (int i = 0; i < 3; i++) begin
				prod_s9[i] <= $signed({1'b0, t_c}) * $signed(dv_side.v[i]);
				tp_s9[i]   <= dv_side.tp[i];
			end
			t_s9      <= t_c;
			status_s9 <= dv_side.status;

			out_q.lead_x       <= lead_sat_c[0];
			out_q.lead_y       <= lead_sat_c[1];
			out_q.lead_z       <= lead_sat_c[2];
			out_q.lead_time    <= t_s9;
			out_q.solve_status <= status_s9;
		end
	end

	ils_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s6),
		.in_rad   (d_s6),
		.in_side  (side_s6),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	ils_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s8),
		.in_num   (num_s8),
		.in_den   (den_s8),
		.in_side  (side_s8),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	a_fail_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.solve_status == ST_NO_MOTION
		|| out_data.solve_status == ST_NO_ROOT
		|| out_data.solve_status == ST_ZERO_DIV) |-> out_data.lead_time == 32'd0)
		else $error("failed solve carries nonzero lead time");

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_item_reaches_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s5 |=> vld_s6)
		else $error("item lost before square root");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the intercept lead solver against a predictor of its own.
//
// A short table of target queries covers field extremes, no relative motion,
// the linear case with both signs of closing rate, a zero divisor, no real
// root and no positive root. About 1650 random queries follow, spread over
// several projectile speeds. Each result is compared field by field with the
// oldest predicted aim point. Both channels stall at random, and the result
// side holds off once for a long stretch so that the pipeline fills up.
// ----------------------------------------------------------------------------
module tb_top;
	import ils_pkg::*;

	localparam int  LIMIT    = 400000;
	localparam int  DRAIN    = 150;
	localparam int  IDLE_PCT = 22;
	localparam int  HOLD_LEN = 400;
	localparam int  RAND_PER = 275;
	localparam logic [30:0] SPD_MAX = 31'h7FFF_FFFF;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		query_t      q;
		logic [30:0] spd;
		bit          typed;
		result_t     res;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	query_t      in_data = '0;
	logic        out_valid;
	logic        out_ready = 0;
	result_t     out_data;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [30:0] cfg_data = '0;

	logic [30:0] speed_q = '0;
	result_t     lead_due[$];
	int          errors = 0;
	int          cycles = 0;
	int          queries = 0;
	int          results = 0;
	bit          no_idle = 0;
	bit          hold_req = 0;
	row_t        rows[$];

	intercept_lead_solver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic wide_t sat(wide_t x, wide_t lo, wide_t hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic logic [31:0] div_sat(wide_t num, wide_t den);
		wide_t qt;
		if (den == 0)
			return 32'hFFFF_FFFF;
		if (num >= (den <<< 32))
			return 32'hFFFF_FFFF;
		qt = num / den;
		return qt[31:0];
	endfunction

	function automatic result_t solve_lead(query_t q, logic [30:0] spd);
		wide_t sh[3], shv[3], tp[3], tv[3], p[3], v[3];
		wide_t v2, c, h, s2, a, amag, hmag, d, sq, cand, base, n1, n2, nsel;
		wide_t t, off, ld;
		logic [1:0] st;
		result_t r;
		sh[0] = 128'($signed(q.shooter_px)); sh[1] = 128'($signed(q.shooter_py));
		sh[2] = 128'($signed(q.shooter_pz));
		shv[0] = 128'($signed(q.shooter_vx)); shv[1] = 128'($signed(q.shooter_vy));
		shv[2] = 128'($signed(q.shooter_vz));
		tp[0] = 128'($signed(q.target_px)); tp[1] = 128'($signed(q.target_py));
		tp[2] = 128'($signed(q.target_pz));
		tv[0] = 128'($signed(q.target_vx)); tv[1] = 128'($signed(q.target_vy));
		tv[2] = 128'($signed(q.target_vz));
		v2 = 0; c = 0; h = 0; t = 0; st = ST_SOLVED;
		for (int i = 0; i < 3; i++) begin
			p[i] = sat(tp[i] - sh[i], -128'sd1073741824, 128'sd1073741823);
			v[i] = sat(tv[i] - shv[i], -128'sd1073741824, 128'sd1073741823);
			v2 += v[i] * v[i];
			c += p[i] * p[i];
			h += v[i] * p[i];
		end
		if (v2 < 16778) begin
			st = ST_NO_MOTION;
		end else begin
			s2 = $signed({97'd0, spd}) * $signed({97'd0, spd});
			a = v2 - s2;
			amag = a < 0 ? -a : a;
			hmag = h < 0 ? -h : h;
			if (amag < 16778) begin
				if (h == 0)
					st = ST_ZERO_DIV;
				else if (h < 0)
					t = 128'(div_sat(c <<< 15, hmag));
			end else begin
				d = h * h - a * c;
				if (d < 0) begin
					st = ST_NO_ROOT;
				end else begin
					sq = 0;
					for (int b = 62; b >= 0; b--) begin
						cand = sq | (128'sd1 <<< b);
						if (cand * cand <= d)
							sq = cand;
					end
					base = a > 0 ? -h : h;
					n1 = base - sq;
					n2 = base + sq;
					nsel = n1 > 0 ? n1 : (n2 > 0 ? n2 : 0);
					if (nsel > 0)
						t = 128'(div_sat(nsel <<< 16, amag));
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			off = (t * v[i]) >>> 16;
			ld = sat(tp[i] + off, -128'sd2147483648, 128'sd2147483647);
			if (i == 0) r.lead_x = ld[31:0];
			if (i == 1) r.lead_y = ld[31:0];
			if (i == 2) r.lead_z = ld[31:0];
		end
		r.lead_time = t[31:0];
		r.solve_status = st;
		return r;
	endfunction

	function automatic query_t mk_query(longint spx, longint spy, longint spz,
			longint svx, longint svy, longint svz, longint tpx, longint tpy,
			longint tpz, longint tvx, longint tvy, longint tvz);
		query_t q;
		q.shooter_px = 32'(spx); q.shooter_py = 32'(spy); q.shooter_pz = 32'(spz);
		q.shooter_vx = 32'(svx); q.shooter_vy = 32'(svy); q.shooter_vz = 32'(svz);
		q.target_px = 32'(tpx); q.target_py = 32'(tpy); q.target_pz = 32'(tpz);
		q.target_vx = 32'(tvx); q.target_vy = 32'(tvy); q.target_vz = 32'(tvz);
		return q;
	endfunction

	function automatic result_t mk_res(longint x, longint y, longint z,
			longint t, logic [1:0] st);
		result_t r;
		r.lead_x = 32'(x); r.lead_y = 32'(y); r.lead_z = 32'(z);
		r.lead_time = 32'(t); r.solve_status = st;
		return r;
	endfunction

	function automatic logic signed [31:0] rnd_span(int bits);
		logic signed [31:0] x;
		x = $signed($urandom());
		return x >>> (32 - bits);
	endfunction

	function automatic query_t rand_query(logic [30:0] spd);
		query_t q;
		int kind;
		logic signed [31:0] m;
		kind = $urandom_range(99);
		q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		if (kind < 25)
			return q;
		q.shooter_px = rnd_span(25); q.shooter_py = rnd_span(25);
		q.shooter_pz = rnd_span(25); q.target_px = rnd_span(25);
		q.target_py = rnd_span(25); q.target_pz = rnd_span(25);
		q.shooter_vx = rnd_span(19); q.shooter_vy = rnd_span(19);
		q.shooter_vz = rnd_span(19); q.target_vx = rnd_span(19);
		q.target_vy = rnd_span(19); q.target_vz = rnd_span(19);
		if (kind < 35) begin
			q.target_vx = q.shooter_vx + rnd_span(6);
			q.target_vy = q.shooter_vy + rnd_span(6);
			q.target_vz = q.shooter_vz + rnd_span(6);
		end else if (kind < 55) begin
			m = $signed({1'b0, spd}) + $signed(rnd_span(2));
			q.shooter_vx = 0; q.shooter_vy = 0; q.shooter_vz = 0;
			q.target_vx = $urandom_range(1) ? m : -m;
			q.target_vy = 0; q.target_vz = 0;
			if ($urandom_range(3) == 0)
				q.target_px = q.shooter_px;
		end else if (kind < 65) begin
			q.shooter_vx = rnd_span(32); q.target_vx = rnd_span(32);
			q.target_px = rnd_span(32); q.shooter_px = rnd_span(32);
		end
		return q;
	endfunction

	task automatic write_speed(logic [30:0] spd);
		@(negedge clk);
		while (lead_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_valid <= 1;
		cfg_data <= spd;
		do @(posedge clk); while (!cfg_ready);
		speed_q = spd;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_query(query_t q, bit typed, result_t res);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= q;
		do @(posedge clk); while (!in_ready);
		lead_due.push_back(typed ? res : solve_lead(q, speed_q));
		queries++;
	endtask

	task automatic add_row(query_t q, logic [30:0] spd, bit typed, result_t res);
		row_t r;
		r.q = q; r.spd = spd; r.typed = typed; r.res = res;
		rows.push_back(r);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 0;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[intercept_lead_solver] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			results++;
			if (lead_due.size() == 0) begin
				$error("unexpected result %h", out_data);
				errors++;
			end else begin
				e = lead_due.pop_front();
				if (out_data.lead_x !== e.lead_x) begin
					$error("lead_x exp %h got %h", e.lead_x, out_data.lead_x);
					errors++;
				end
				if (out_data.lead_y !== e.lead_y) begin
					$error("lead_y exp %h got %h", e.lead_y, out_data.lead_y);
					errors++;
				end
				if (out_data.lead_z !== e.lead_z) begin
					$error("lead_z exp %h got %h", e.lead_z, out_data.lead_z);
					errors++;
				end
				if (out_data.lead_time !== e.lead_time) begin
					$error("lead_time exp %h got %h", e.lead_time, out_data.lead_time);
					errors++;
				end
				if (out_data.solve_status !== e.solve_status) begin
					$error("solve_status exp %0d got %0d", e.solve_status,
						out_data.solve_status);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [30:0] speeds[6];
		result_t none;
		none = '0;
		add_row('0, 0, 1, mk_res(0, 0, 0, 0, ST_NO_MOTION));
		add_row(mk_query(0, 0, 0, 77, -5, 9, 32'h7FFFFFFF, -32'sh80000000, 1,
			77, -5, 9), 0, 1, mk_res(32'h7FFFFFFF, -32'sh80000000, 1, 0, ST_NO_MOTION));
		add_row(mk_query(-32'sh80000000, -32'sh80000000, -32'sh80000000,
			-32'sh80000000, -32'sh80000000, -32'sh80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF),
			0, 0, none);
		add_row(mk_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -32'sh80000000,
			-32'sh80000000, -32'sh80000000, -32'sh80000000, -32'sh80000000,
			-32'sh80000000), 0, 0, none);
		add_row(mk_query(0, 0, 0, 0, 0, 0, 40960, 8192, -4096, 4096, 0, 0), 0, 0, none);
		add_row(mk_query(0, 0, 0, 0, 0, 0, 40960, 0, 0, 4096, 0, 0), 1, 0, none);
		add_row(mk_query(0, 0, 0, 0, 0, 0, 0, 4096, 0, 4096, 0, 0), 4096, 1,
			mk_res(0, 4096, 0, 0, ST_ZERO_DIV));
		add_row(mk_query(0, 0, 0, 0, 0, 0, 40960, 0, 0, -4096, 0, 0), 4096, 1,
			mk_res(20480, 0, 0, 327680, ST_SOLVED));
		add_row(mk_query(0, 0, 0, 0, 0, 0, -40960, 0, 0, -4096, 0, 0), 4096, 1,
			mk_res(-40960, 0, 0, 0, ST_SOLVED));
		add_row(mk_query(0, 0, 0, 0, 0, 0, 0, 40960, 0, 8192, 0, 0), 4096, 1,
			mk_res(0, 40960, 0, 0, ST_NO_ROOT));
		add_row(mk_query(0, 0, 0, 0, 0, 0, 40960, 0, 0, 8192, 0, 0), 4096, 1,
			mk_res(40960, 0, 0, 0, ST_SOLVED));
		add_row(mk_query(0, 0, 0, 0, 0, 0, 40960, 0, 0, 2048, 0, 0), 4096, 0, none);
		add_row(mk_query(0, 0, 0, 0, 0, 0, 40960, 0, 0, -2048, 0, 0), 4096, 0, none);
		add_row(mk_query(1, 2, 3, 0, 0, 0, 32'h7FFFF000, 5, 6, 32'h7FFFFFFF, 0, 0),
			SPD_MAX, 0, none);
		add_row(mk_query(-32'sh80000000, 0, 0, 4096, 0, 0, 32'h7FFFFFFF, 0, 0,
			-32'sh80000000, 0, 0), SPD_MAX, 0, none);
		add_row(mk_query(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, -32'sh80000000, 0,
			1 << 20, -(1 << 20), 0), SPD_MAX, 0, none);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		foreach (rows[i]) begin
			if (rows[i].spd != speed_q || i == 0) begin
				@(negedge clk);
				in_valid <= 0;
				write_speed(rows[i].spd);
			end
			send_query(rows[i].q, rows[i].typed, rows[i].res);
		end

		speeds[0] = 0;
		speeds[1] = SPD_MAX;
		speeds[2] = 31'($urandom_range(1 << 14));
		speeds[3] = 31'($urandom() >> 1);
		speeds[4] = 4096;
		speeds[5] = 31'($urandom_range(1 << 20));
		for (int ph = 0; ph < 6; ph++) begin
			@(negedge clk);
			in_valid <= 0;
			write_speed(speeds[ph]);
			no_idle = (ph == 2);
			hold_req = (ph == 1);
			for (int k = 0; k < RAND_PER; k++)
				send_query(rand_query(speed_q), 0, none);
		end
		@(negedge clk);
		in_valid <= 0;
		no_idle = 0;
		while (lead_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("covered %0d queries and %0d results: directed rows, six random speed phases",
			queries, results);
		$display("directed extremes, linear, zero divisor and no-root cases included");
		if (errors == 0)
			$display("[intercept_lead_solver] OK");
		else
			$display("[intercept_lead_solver] ERROR");
		$finish;
	end

endmodule
